FILE: design/mrsp_pkg.sv
package mrsp_pkg;

   // result command codes
   typedef enum logic [2:0] {
      CMD_NOTE_OFF   = 3'd0,
      CMD_NOTE_ON    = 3'd1,
      CMD_CONTROLLER = 3'd2,
      CMD_PROGRAM    = 3'd3,
      CMD_PITCH_BEND = 3'd4
   } command_type;

   // status byte high nibbles
   localparam logic [3:0] STAT_NOTE_OFF   = 4'h8;
   localparam logic [3:0] STAT_NOTE_ON    = 4'h9;
   localparam logic [3:0] STAT_AFTERTOUCH = 4'hA;
   localparam logic [3:0] STAT_CONTROLLER = 4'hB;
   localparam logic [3:0] STAT_PROGRAM    = 4'hC;
   localparam logic [3:0] STAT_PITCH_BEND = 4'hE;

   // lowest realtime byte
   localparam logic [7:0] REALTIME_MIN = 8'hF8;

   localparam int RSP_DATA_W = 40;

   // registered input byte handed to the decoder
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
   } in_item_type;

   typedef struct packed {
      logic signed [13:0] bend;
      logic [6:0]         second_value;
      logic [6:0]         first_value;
      logic [3:0]         channel;
      command_type        command;
   } result_type;

endpackage

FILE: design/midi_running_status_parser.sv
// midi running status parser
// req channel: one raw midi byte per transaction on req_tdata; bytes with
//   bit 7 set are status, 0xf8 and up are realtime and are dropped
// rsp channel: one decoded channel message per transaction; note off/on,
//   controller, program change and pitch bend, with channel and values
// a byte is registered in the input stage, decoded against the running
//   status in one pass and the result lands in the output register
// path: a byte that completes a message passes the input register, then the
//   result register to rsp_tvalid; bytes that complete nothing give no transaction
// throughput: one byte per cycle while no result waits on rsp_tready, set
//   by the single-pass decode between the input and result registers
// stall: while rsp_tready is low and a result waits, the input stage still
//   takes one byte; req_tready drops once that byte is also held
// reset: running status, data position and first byte clear to zero, so
//   data bytes before any status byte are ignored; both channels go empty
module midi_running_status_parser
   import mrsp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [2:0] command, [6:3] channel,
                                              // [13:7] first_value,
                                              // [20:14] second_value,
                                              // [34:21] bend, [39:35] zero
);

   in_item_type item;
   logic        consume;
   result_type  result;

   // input register
   mrsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .consume    (consume),
      .item       (item)
   );

   // parser state, decode and result register
   mrsp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .item      (item),
      .consume   (consume),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .result    (result)
   );

   // result fields packed from the lowest bit up, zero filled to 40 bits
   assign rsp_tdata = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, result};

endmodule

FILE: design/mrsp_in_stage.sv
module mrsp_in_stage
   import mrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        consume,
   output in_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;

   // stage frees up when empty or when the decoder takes its byte this cycle
   assign req_tready = !valid_ff || consume;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item.valid     = valid_ff;
   assign item.data_byte = byte_ff;

endmodule

FILE: design/mrsp_decode.sv
module mrsp_decode
   import mrsp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  in_item_type item,
   output logic        consume,
   output logic        out_valid,
   input  logic        out_ready,
   output result_type  result
);

   logic [7:0] status_ff, status_in;
   logic       pos_ff, pos_in;
   logic [6:0] held_ff, held_in;
   logic       out_valid_ff, out_valid_in;
   result_type result_ff, result_in;

   logic       hit;
   result_type res;
   logic [7:0] b;
   logic [3:0] chan;

   assign b       = item.data_byte;
   assign chan    = status_ff[3:0];
   // byte is processed once the result register can take whatever it yields
   assign consume = item.valid && (!out_valid_ff || out_ready);

   always_comb begin
      status_in        = status_ff;
      pos_in           = pos_ff;
      held_in          = held_ff;
      hit              = 1'b0;
      res.command      = CMD_NOTE_OFF;
      res.channel      = chan;
      res.first_value  = held_ff;
      res.second_value = b[6:0];
      res.bend         = '0;
      if (b[7]) begin
         if (b < REALTIME_MIN) begin
            status_in = b;
            pos_in    = 1'b0;
         end
      end else begin
         unique case (status_ff[7:4]) inside
            STAT_NOTE_OFF, STAT_NOTE_ON, STAT_AFTERTOUCH,
            STAT_CONTROLLER, STAT_PITCH_BEND: begin
               // two-byte messages share the pair counter
               if (!pos_ff) begin
                  held_in = b[6:0];
                  pos_in  = 1'b1;
               end else begin
                  pos_in = 1'b0;
                  hit    = (status_ff[7:4] != STAT_AFTERTOUCH);
               end
               if (status_ff[7:4] == STAT_CONTROLLER) begin
                  res.command = CMD_CONTROLLER;
               end else if (status_ff[7:4] == STAT_PITCH_BEND) begin
                  res.command      = CMD_PITCH_BEND;
                  res.first_value  = '0;
                  res.second_value = '0;
                  // (lsb | msb << 7) - 0x2000 flips the top bit
                  res.bend = {~b[6], b[5:0], held_ff};
               end else if (status_ff[4] && b[6:0] != 7'd0) begin
                  res.command = CMD_NOTE_ON;
               end
            end
            STAT_PROGRAM: begin
               hit              = 1'b1;
               res.command      = CMD_PROGRAM;
               res.first_value  = b[6:0];
               res.second_value = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      result_in    = result_ff;
      if (consume) begin
         out_valid_in = hit;
         result_in    = res;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= '0;
         pos_ff       <= 1'b0;
         held_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (consume) begin
            status_ff <= status_in;
            pos_ff    <= pos_in;
            held_ff   <= held_in;
         end
      end
      result_ff <= result_in;
   end

   assign out_valid = out_valid_ff;
   assign result    = result_ff;

   a_realtime_keeps_state: assert property (@(posedge clock) disable iff (reset)
      consume && b >= REALTIME_MIN |=> $stable(status_ff) && $stable(pos_ff))
      else $error("realtime byte changed parser state");

   a_status_clears_pos: assert property (@(posedge clock) disable iff (reset)
      consume && b[7] && b < REALTIME_MIN |=> !pos_ff && status_ff == $past(b))
      else $error("status byte not latched");

   a_note_on_velocity: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.command == CMD_NOTE_ON |-> result_ff.second_value != 7'd0)
      else $error("note on with zero velocity");

   a_bend_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && result_ff.command != CMD_PITCH_BEND |-> result_ff.bend == '0)
      else $error("bend set on non pitch bend result");

   a_no_result_from_idle: assert property (@(posedge clock) disable iff (reset)
      !item.valid && !out_valid_ff |=> !out_valid_ff)
      else $error("result without a transaction");

endmodule

FILE: tb/sv/midi_running_status_parser_test.sv
`timescale 1ns / 100ps

// byte-level check of the midi running status parser: a queue of raw bytes
// feeds the req stream, an in-bench decoder predicts each channel message and
// the rsp stream is compared field by field against the oldest prediction
module midi_running_status_parser_test;
   import mrsp_pkg::*;

   localparam int          RANDOM_ITEMS   = 1200;
   localparam int          IDLE_PERCENT   = 12;
   localparam int          RESET_CYCLES   = 12;
   localparam int          DRAIN_CYCLES   = 8;
   localparam int          CYCLE_LIMIT    = 200000;
   localparam int          CALM_FIRST     = 500;   // window of transactions with no idling
   localparam int          CALM_LAST      = 800;
   localparam logic [3:0]  STAT_PRESSURE  = 4'hD;
   localparam logic [3:0]  STAT_SYSTEM    = 4'hF;
   localparam logic [13:0] BEND_CENTER    = 14'h2000;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = 8'h00;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // bytes waiting to be sent, and messages waiting to come out
   logic [7:0]            byte_backlog[$];
   result_type            message_queue[$];

   // decoder state mirrored in the bench
   logic [7:0]            run_status = 8'h00;
   logic                  second_pending = 1'b0;
   logic [6:0]            first_held = 7'h00;

   int                    queued_items   = 0;
   int                    accepted_items = 0;
   int                    error_count    = 0;
   int                    cycle_count    = 0;
   logic                  req_taken      = 1'b0;
   logic                  calm;

   assign calm = accepted_items >= CALM_FIRST && accepted_items < CALM_LAST;

   midi_running_status_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // two-byte message bookkeeping; true once the second byte has arrived
   function automatic bit take_pair(input logic [6:0] data);
      if (!second_pending) begin
         first_held     = data;
         second_pending = 1'b1;
         return 1'b0;
      end
      second_pending = 1'b0;
      return 1'b1;
   endfunction

   // decode one byte against the running status; true when a message completes
   function automatic bit decode_midi_byte(input logic [7:0] b, output result_type msg);
      logic [3:0]  chan;
      logic [13:0] raw;
      chan = run_status[3:0];
      msg  = '0;
      msg.channel = chan;
      if (b[7]) begin
         // realtime bytes leave everything alone, other status bytes latch
         if (b < REALTIME_MIN) begin
            run_status     = b;
            second_pending = 1'b0;
         end
         return 1'b0;
      end
      case (run_status[7:4]) inside
         STAT_NOTE_OFF, STAT_NOTE_ON: begin
            if (!take_pair(b[6:0]))
               return 1'b0;
            // note on with zero velocity is a note off
            if (b == 8'h00 || run_status[7:4] == STAT_NOTE_OFF)
               msg.command = CMD_NOTE_OFF;
            else
               msg.command = CMD_NOTE_ON;
            msg.first_value  = first_held;
            msg.second_value = b[6:0];
            return 1'b1;
         end
         STAT_AFTERTOUCH: begin
            // counted in pairs, never reported
            void'(take_pair(b[6:0]));
            return 1'b0;
         end
         STAT_CONTROLLER: begin
            if (!take_pair(b[6:0]))
               return 1'b0;
            msg.command      = CMD_CONTROLLER;
            msg.first_value  = first_held;
            msg.second_value = b[6:0];
            return 1'b1;
         end
         STAT_PROGRAM: begin
            msg.command     = CMD_PROGRAM;
            msg.first_value = b[6:0];
            return 1'b1;
         end
         STAT_PITCH_BEND: begin
            if (!take_pair(b[6:0]))
               return 1'b0;
            raw         = {b[6:0], first_held} - BEND_CENTER;
            msg.command = CMD_PITCH_BEND;
            msg.bend    = raw;
            return 1'b1;
         end
         default: return 1'b0;   // pressure, system and pre-status data
      endcase
   endfunction

   task automatic queue_byte(input logic [7:0] b);
      byte_backlog.push_back(b);
      if (b < REALTIME_MIN)
         queued_items++;
   endtask

   task automatic queue_realtime();
      logic [2:0] low;
      low = 3'($urandom_range(0, 7));
      queue_byte({5'b11111, low});
   endtask

   // mostly well-formed messages under running status, with realtime bytes
   // sprinkled between data and a share of raw noise
   task automatic queue_random_traffic();
      int         roll;
      int         msgs;
      int         per_msg;
      logic [7:0] gen_status;
      logic [3:0] nib;
      logic [3:0] chan;
      logic [2:0] sys_low;
      logic [7:0] data;
      gen_status = 8'h00;
      queued_items = 0;
      while (queued_items < RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 85) begin
            if (roll < 55 || gen_status == 8'h00) begin
               nib  = 4'($urandom_range(8, 15));
               chan = 4'($urandom_range(0, 15));
               if (nib == STAT_SYSTEM) begin
                  sys_low    = 3'($urandom_range(0, 7));
                  gen_status = {STAT_SYSTEM, 1'b0, sys_low};
               end else begin
                  gen_status = {nib, chan};
               end
               queue_byte(gen_status);
            end
            case (gen_status[7:4]) inside
               STAT_PROGRAM, STAT_PRESSURE: per_msg = 1;
               STAT_SYSTEM:                 per_msg = $urandom_range(0, 2);
               default:                     per_msg = 2;
            endcase
            msgs = $urandom_range(1, 3);
            for (int m = 0; m < msgs; m++) begin
               for (int k = 0; k < per_msg; k++) begin
                  if ($urandom_range(0, 19) == 0)
                     queue_realtime();
                  data = 8'($urandom_range(0, 127));
                  // zero velocity turns up now and then
                  if (k == per_msg - 1 && $urandom_range(0, 7) == 0)
                     data = 8'h00;
                  queue_byte(data);
               end
            end
         end else begin
            data = 8'($urandom_range(0, 255));
            queue_byte(data);
         end
      end
   endtask

   // sender: hold a presented byte until it is taken, else decide afresh
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         req_tvalid <= 1'b1;
      end else if (byte_backlog.size() == 0 ||
                   (!calm && $urandom_range(0, 99) < IDLE_PERCENT)) begin
         req_tvalid <= 1'b0;
      end else begin
         req_tvalid <= 1'b1;
         req_tdata  <= byte_backlog[0];
      end
   end

   // receiver: random back-pressure outside the calm window
   always @(negedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
   end

   // req transaction: retire the byte and predict what it produces
   always @(posedge clock) begin
      result_type msg;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         void'(byte_backlog.pop_front());
         accepted_items++;
         if (decode_midi_byte(req_tdata, msg))
            message_queue.push_back(msg);
      end
   end

   // rsp transaction: compare against the oldest predicted message
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(result_type)-1:0];
         if (message_queue.size() == 0) begin
            $error("unexpected message: command %0d channel %0d", got.command, got.channel);
            error_count++;
         end else begin
            want = message_queue.pop_front();
            if (got.command !== want.command) begin
               $error("command: expected %0d, actual %0d", want.command, got.command);
               error_count++;
            end
            if (got.channel !== want.channel) begin
               $error("channel: expected %0d, actual %0d", want.channel, got.channel);
               error_count++;
            end
            if (got.first_value !== want.first_value) begin
               $error("first_value: expected %0d, actual %0d",
                      want.first_value, got.first_value);
               error_count++;
            end
            if (got.second_value !== want.second_value) begin
               $error("second_value: expected %0d, actual %0d",
                      want.second_value, got.second_value);
               error_count++;
            end
            if (got.bend !== want.bend) begin
               $error("bend: expected %0d, actual %0d", want.bend, got.bend);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // data ahead of any status byte is dropped
      queue_byte(8'h05);
      queue_byte(8'h7F);
      // note on, then running status with zero velocity as note off
      queue_byte(8'h90);
      queue_byte(8'h3C);
      queue_byte(8'h64);
      queue_byte(8'h3C);
      queue_byte(8'h00);
      // note off status keeps a nonzero velocity as note off
      queue_byte(8'h8F);
      queue_byte(8'h40);
      queue_byte(8'h7F);
      // controller
      queue_byte(8'hBF);
      queue_byte(8'h07);
      queue_byte(8'h7F);
      // program change gives one message per byte
      queue_byte(8'hC3);
      queue_byte(8'h00);
      queue_byte(8'h7F);
      // bend at both ends, realtime wedged between the two bytes
      queue_byte(8'hE0);
      queue_byte(8'h00);
      queue_byte(8'h00);
      queue_byte(8'hEF);
      queue_byte(8'h7F);
      queue_byte(8'hFF);
      queue_byte(8'h7F);
      // aftertouch, channel pressure and system exclusive stay quiet
      queue_byte(8'hA1);
      queue_byte(8'h10);
      queue_byte(8'h20);
      queue_byte(8'hD2);
      queue_byte(8'h11);
      queue_byte(8'hF0);
      queue_byte(8'h01);

      // hold off until the directed part has fully drained
      while (byte_backlog.size() != 0 || message_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      queue_random_traffic();

      while (byte_backlog.size() != 0 || message_queue.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0 && message_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
design/mrsp_pkg.sv
design/mrsp_in_stage.sv
design/mrsp_decode.sv
design/midi_running_status_parser.sv
tb/sv/midi_running_status_parser_test.sv
